// ===== rtl/core/multi_axis_ewma_torque_limit_monitor_top_macros.svh =====
// assertion helpers shared by the monitor rtl
`ifndef MULTI_AXIS_EWMA_TORQUE_LIMIT_MONITOR_TOP_MACROS_SVH
`define MULTI_AXIS_EWMA_TORQUE_LIMIT_MONITOR_TOP_MACROS_SVH

// same-cycle implication
`define MEWMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MEWMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mewma_pkg.sv =====
package mewma_pkg;

  localparam int unsigned MAX_MOTORS      = 3;
  localparam int unsigned DEF_MOTOR_COUNT = 3;

  localparam int unsigned TORQUE_W = 16;
  localparam int unsigned ADJ_W    = 17;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned ALPHA_W  = 17;
  localparam int unsigned SMOOTH_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd2;

  localparam logic [LIMIT_W-1:0]         LIMIT_RST  = 7'd100;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 16'sd0;
  localparam logic [ALPHA_W-1:0]         ALPHA_RST  = 17'd13107;
  localparam logic [ALPHA_W-1:0]         ALPHA_ONE  = 17'h10000;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic ld1;
    logic ld2;
  } lane_ctrl_t;

endpackage

// ===== rtl/core/mewma_in_if.sv =====
interface mewma_in_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      command;
  logic signed [mewma_pkg::TORQUE_W-1:0]     raw_torque_a;
  logic signed [mewma_pkg::TORQUE_W-1:0]     raw_torque_b;
  logic signed [mewma_pkg::TORQUE_W-1:0]     raw_torque_c;
  logic [mewma_pkg::MAX_MOTORS-1:0]          reading_valid_mask;
  logic [mewma_pkg::MAX_MOTORS-1:0]          steps_done_mask;
  logic [mewma_pkg::MAX_MOTORS-1:0]          drive_enabled_mask;

  modport source (
    output valid, command, raw_torque_a, raw_torque_b, raw_torque_c,
           reading_valid_mask, steps_done_mask, drive_enabled_mask,
    input  ready
  );

  modport sink (
    input  valid, command, raw_torque_a, raw_torque_b, raw_torque_c,
           reading_valid_mask, steps_done_mask, drive_enabled_mask,
    output ready
  );
endinterface

// ===== rtl/core/mewma_out_if.sv =====
interface mewma_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  limit_exceeded;
  logic signed [mewma_pkg::ADJ_W-1:0]    adjusted_torque_a;
  logic signed [mewma_pkg::ADJ_W-1:0]    adjusted_torque_b;
  logic signed [mewma_pkg::ADJ_W-1:0]    adjusted_torque_c;
  logic [mewma_pkg::MAX_MOTORS-1:0]      adjusted_valid_mask;

  modport source (
    output valid, limit_exceeded, adjusted_torque_a, adjusted_torque_b,
           adjusted_torque_c, adjusted_valid_mask,
    input  ready
  );

  modport sink (
    input  valid, limit_exceeded, adjusted_torque_a, adjusted_torque_b,
           adjusted_torque_c, adjusted_valid_mask,
    output ready
  );
endinterface

// ===== rtl/core/mewma_lane.sv =====
module mewma_lane (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  mewma_pkg::lane_ctrl_t                      ctrl_i,
  input  logic                                       cmd_i,
  input  logic signed [mewma_pkg::TORQUE_W-1:0]      raw_i,
  input  logic                                       valid_i,
  input  logic                                       done_i,
  input  logic                                       moving_i,
  input  logic [mewma_pkg::ALPHA_W-1:0]              alpha_i,
  input  logic signed [mewma_pkg::OFFSET_W-1:0]      offset_i,
  input  logic [mewma_pkg::LIMIT_W-1:0]              limit_i,
  output logic signed [mewma_pkg::ADJ_W-1:0]         adj_o,
  output logic                                       trip_o,
  output logic                                       upd_o
);

  localparam int unsigned TW  = mewma_pkg::TORQUE_W;
  localparam int unsigned SW  = mewma_pkg::SMOOTH_W;
  localparam int unsigned AW  = mewma_pkg::ALPHA_W;
  localparam int unsigned P1W = AW + TW;
  localparam int unsigned P2W = AW + 1 + SW;
  localparam int unsigned FW  = SW + 2;

  // stage 1: new-reading product
  logic signed [AW:0]      alpha_s;
  logic signed [AW+TW:0]   prod1;
  logic signed [P1W-1:0]   p1_d, p1_q;
  logic signed [TW-1:0]    raw1_q;
  logic                    upd1_d, upd1_q;
  logic                    clr1_q;
  logic                    done1_q;

  assign alpha_s = signed'({1'b0, alpha_i});
  assign prod1   = (AW+TW+1)'(alpha_s) * (AW+TW+1)'(raw_i);
  assign p1_d    = prod1[P1W-1:0];
  assign upd1_d  = (cmd_i == mewma_pkg::CMD_TICK) && moving_i && valid_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      p1_q    <= p1_d;
      raw1_q  <= raw_i;
      upd1_q  <= upd1_d;
      clr1_q  <= (cmd_i == mewma_pkg::CMD_CLEAR);
      done1_q <= done_i;
    end
  end

  // stage 2: average update
  logic [AW-1:0]           beta;
  logic signed [AW:0]      beta_s;
  logic signed [P2W-1:0]   prod2;
  logic signed [P2W-1:0]   prod2_rnd;
  logic signed [P1W-1:0]   decay;
  logic signed [P1W:0]     ewma;
  logic signed [SW-1:0]    s_d, s_q;
  logic                    pend_d, pend_q;
  logic                    upd2_q;
  logic                    done2_q;

  assign beta      = mewma_pkg::ALPHA_ONE - alpha_i;
  assign beta_s    = signed'({1'b0, beta});
  assign prod2     = P2W'(beta_s) * P2W'(s_q);
  assign prod2_rnd = prod2 + P2W'(32768);
  assign decay     = prod2_rnd[P1W+15:16];
  assign ewma      = (P1W+1)'(p1_q) + (P1W+1)'(decay);

  always_comb begin
    s_d    = s_q;
    pend_d = pend_q;
    if (ctrl_i.ld2) begin
      if (clr1_q) begin
        s_d    = '0;
        pend_d = 1'b1;
      end else if (upd1_q) begin
        pend_d = 1'b0;
        if (pend_q) begin
          s_d = signed'({raw1_q, 16'h0000});
        end else begin
          s_d = ewma[SW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q    <= '0;
      pend_q <= 1'b1;
    end else begin
      s_q    <= s_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld2) begin
      upd2_q  <= upd1_q;
      done2_q <= done1_q;
    end
  end

  // result from the updated average
  logic signed [FW-1:0]    full;
  logic signed [FW-1:0]    lim;
  logic signed [SW:0]      rsum;
  logic signed [AW-1:0]    rnd;
  logic signed [AW:0]      adj_full;

  assign full     = FW'(s_q) + FW'(signed'({offset_i, 16'h0000}));
  assign lim      = signed'({3'b000, limit_i, 24'h000000});
  assign trip_o   = upd2_q && !done2_q && ((full > lim) || (full < -lim));
  assign rsum     = (SW+1)'(s_q) + (SW+1)'(32768);
  assign rnd      = rsum[SW:16];
  assign adj_full = (AW+1)'(rnd) + (AW+1)'(offset_i);
  assign adj_o    = upd2_q ? adj_full[mewma_pkg::ADJ_W-1:0] : '0;
  assign upd_o    = upd2_q;

endmodule

// ===== rtl/core/mewma_merge.sv =====
module mewma_merge (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic signed [mewma_pkg::ADJ_W-1:0]       adj_i [mewma_pkg::MAX_MOTORS],
  input  logic [mewma_pkg::MAX_MOTORS-1:0]         trip_i,
  input  logic [mewma_pkg::MAX_MOTORS-1:0]         upd_i,
  mewma_out_if.source                              out_o
);

  logic                                    valid_q;
  logic                                    ld;
  logic                                    limit_q;
  logic signed [mewma_pkg::ADJ_W-1:0]      adj_q [mewma_pkg::MAX_MOTORS];
  logic [mewma_pkg::MAX_MOTORS-1:0]        mask_q;

  assign ready_o = !valid_q || out_o.ready;
  assign ld      = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      limit_q <= |trip_i;
      adj_q   <= adj_i;
      mask_q  <= upd_i;
    end
  end

  assign out_o.valid               = valid_q;
  assign out_o.limit_exceeded      = limit_q;
  assign out_o.adjusted_torque_a   = adj_q[0];
  assign out_o.adjusted_torque_b   = adj_q[1];
  assign out_o.adjusted_torque_c   = adj_q[2];
  assign out_o.adjusted_valid_mask = mask_q;

endmodule

// ===== rtl/core/multi_axis_ewma_torque_limit_monitor_top.sv =====
// each input transaction passes the stage 1, lane average and output registers to result valid
// throughput: one transaction per cycle without output back-pressure, set by the per-motor average loop
//   (one 18x32 multiply and add per lane feeding back into its own register)
// reset: averages cleared, first readings pending, configuration to defaults;
//   no clearing pass, the block accepts transactions right after reset
`include "multi_axis_ewma_torque_limit_monitor_top_macros.svh"

module multi_axis_ewma_torque_limit_monitor_top #(
  parameter int unsigned MOTOR_COUNT = mewma_pkg::DEF_MOTOR_COUNT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mewma_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mewma_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  mewma_in_if.sink                               in_i,
  mewma_out_if.source                            out_o
);

  localparam int unsigned NM = mewma_pkg::MAX_MOTORS;

  // configuration
  logic [mewma_pkg::LIMIT_W-1:0]          limit_q;
  logic signed [mewma_pkg::OFFSET_W-1:0]  offset_q;
  logic [mewma_pkg::ALPHA_W-1:0]          alpha_q;
  logic [mewma_pkg::ALPHA_W-1:0]          alpha_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= mewma_pkg::LIMIT_RST;
      offset_q <= mewma_pkg::OFFSET_RST;
      alpha_q  <= mewma_pkg::ALPHA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mewma_pkg::CFG_LIMIT:  limit_q  <= cfg_wdata_i[mewma_pkg::LIMIT_W-1:0];
        mewma_pkg::CFG_OFFSET: offset_q <= signed'(cfg_wdata_i[mewma_pkg::OFFSET_W-1:0]);
        mewma_pkg::CFG_ALPHA:  alpha_q  <= cfg_wdata_i[mewma_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  assign alpha_sat = (alpha_q > mewma_pkg::ALPHA_ONE) ? mewma_pkg::ALPHA_ONE : alpha_q;

  // pipeline control
  logic                   v1_q, v2_q;
  logic                   rdy1, rdy2, rdy_out;
  mewma_pkg::lane_ctrl_t  ctrl;

  assign rdy2      = !v2_q || rdy_out;
  assign rdy1      = !v1_q || rdy2;
  assign in_i.ready = rdy1;
  assign ctrl.ld1  = in_i.valid && rdy1;
  assign ctrl.ld2  = v1_q && rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // lane inputs
  logic signed [mewma_pkg::TORQUE_W-1:0]  raw [NM];
  logic [NM-1:0]                          present;
  logic                                   moving;

  assign raw[0] = in_i.raw_torque_a;
  assign raw[1] = in_i.raw_torque_b;
  assign raw[2] = in_i.raw_torque_c;

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      present[i] = (i < MOTOR_COUNT);
    end
  end

  assign moving = |(~in_i.steps_done_mask & in_i.drive_enabled_mask & present);

  logic signed [mewma_pkg::ADJ_W-1:0]  adj [NM];
  logic [NM-1:0]                       trip;
  logic [NM-1:0]                       upd;

  for (genvar g = 0; g < NM; g++) begin : g_lane
    if (g < MOTOR_COUNT) begin : g_on
      mewma_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .cmd_i    (in_i.command),
        .raw_i    (raw[g]),
        .valid_i  (in_i.reading_valid_mask[g]),
        .done_i   (in_i.steps_done_mask[g]),
        .moving_i (moving),
        .alpha_i  (alpha_sat),
        .offset_i (offset_q),
        .limit_i  (limit_q),
        .adj_o    (adj[g]),
        .trip_o   (trip[g]),
        .upd_o    (upd[g])
      );
    end else begin : g_off
      assign adj[g]  = '0;
      assign trip[g] = 1'b0;
      assign upd[g]  = 1'b0;
    end
  end

  mewma_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .ready_o (rdy_out),
    .adj_i   (adj),
    .trip_i  (trip),
    .upd_i   (upd),
    .out_o   (out_o)
  );

  `MEWMA_ASSERT_NEXT(a_s1_hold, v1_q && !rdy2, v1_q, "stage 1 lost a stalled transaction")
  `MEWMA_ASSERT_NOW(a_ready_full, !in_i.ready, v1_q && v2_q && out_o.valid && !out_o.ready,
                    "input stalled with room in the pipeline")
  `MEWMA_ASSERT_NOW(a_trip_mask, out_o.valid && out_o.limit_exceeded,
                    out_o.adjusted_valid_mask != '0, "limit flagged with no computed motor")

endmodule
